@@ sv/baas_pkg.sv @@
package baas_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USE_ALPHA    = 3'd4;

    // register widths
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 13;
    localparam int TILE_W  = 5;

    // image height limit and row counter width
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 12;

    // pixel and sum widths
    localparam int CHAN_W = 8;
    localparam int SUM_W  = 16;
    localparam int MEAN_W = 8;
    localparam int LUMA_W = 18;

    // luma weights, per mille
    localparam int RED_WEIGHT   = 299;
    localparam int GREEN_WEIGHT = 587;
    localparam int BLUE_WEIGHT  = 114;

    // floor(x / 1000) as (x * GRAY_MULT) >> GRAY_SHIFT, exact for x up to 255000
    localparam int GRAY_MULT_W = 19;
    localparam int GRAY_SHIFT  = 28;
    localparam logic [GRAY_MULT_W-1:0] GRAY_MULT = 19'd268436;

    // floor(y / 255) as (y * IDX_MULT) >> IDX_SHIFT, exact for y up to 2295
    localparam int SCALED_W   = 12;
    localparam int IDX_MULT_W = 13;
    localparam int IDX_SHIFT  = 20;
    localparam logic [IDX_MULT_W-1:0] IDX_MULT = 13'd4113;

    localparam int CODE_W      = 7;
    localparam int RAMP_LEVELS = 10;
    localparam int RAMP_IDX_W  = 4;
    localparam logic [RAMP_IDX_W-1:0] RAMP_TOP = 4'd9;
    localparam logic [CODE_W-1:0] CHAR_SPACE = 7'd32;

    // " .:-=+*M%@"
    localparam logic [CODE_W-1:0] RAMP [RAMP_LEVELS] = '{
        7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd77, 7'd37, 7'd64
    };

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              end_of_line;
        logic              end_of_image;
    } glyph_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

    typedef struct packed {
        logic [IMG_W_W-1:0] image_width;
        logic [IMG_H_W-1:0] image_height;
        logic [TILE_W-1:0]  tile_width;
        logic [TILE_W-1:0]  tile_height;
        logic               use_alpha;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        image_width:  11'd640,
        image_height: 13'd480,
        tile_width:   5'd2,
        tile_height:  5'd2,
        use_alpha:    1'b0
    };

    typedef struct packed {
        logic end_of_line;
        logic end_of_image;
    } tile_flags_t;

    // character for one tile from its mean gray and whether mean alpha is zero
    function automatic logic [CODE_W-1:0] char_of(
        input logic [MEAN_W-1:0] mean_gray,
        input logic              alpha_zero
    );
        logic [SCALED_W-1:0]              scaled;
        logic [SCALED_W+IDX_MULT_W-1:0]   prod;
        logic [RAMP_IDX_W-1:0]            idx;
        scaled = SCALED_W'(mean_gray) * SCALED_W'(RAMP_TOP);
        prod   = (SCALED_W+IDX_MULT_W)'(scaled) * (SCALED_W+IDX_MULT_W)'(IDX_MULT);
        idx    = RAMP_IDX_W'(prod >> IDX_SHIFT);
        if (idx > RAMP_TOP)
        begin
            idx = RAMP_TOP;
        end
        if (alpha_zero)
        begin
            return CHAR_SPACE;
        end
        return RAMP[idx];
    endfunction

endpackage

@@ sv/baas_stream_if.sv @@
interface baas_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/baas_accum.sv @@
module baas_accum import baas_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_TILE  = 16,
    parameter int CNT_W     = $clog2(MAX_TILE * MAX_TILE + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pixel_t            pixel,
    input  cfg_regs_t         cfg_regs,
    input  logic              restart,
    output logic              tile_valid,
    output logic [SUM_W-1:0]  gray_sum,
    output logic [SUM_W-1:0]  alpha_sum,
    output logic [CNT_W-1:0]  tile_count,
    output tile_flags_t       tile_flags
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int TW  = $clog2(MAX_TILE);
    localparam int XW  = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam int TXW = (TW + 1 > TILE_W) ? TW + 1 : TILE_W;
    localparam int PW  = LUMA_W + GRAY_MULT_W;

    function automatic logic [TW-1:0] tile_last(input logic [TILE_W-1:0] v);
        logic [TXW-1:0] vx;
        vx = TXW'(v);
        if (vx == '0)
        begin
            return '0;
        end
        if (vx > TXW'(MAX_TILE))
        begin
            return TW'(MAX_TILE - 1);
        end
        return TW'(vx - TXW'(1));
    endfunction

    // raster position
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [TW-1:0]    cit_reg, cit_next;
    logic [TW-1:0]    rit_reg, rit_next;
    logic [CW-1:0]    slot_reg, slot_next;

    // clamped limits
    logic [XW-1:0]    iw_x;
    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic [TW-1:0]    tw_last;
    logic [TW-1:0]    th_last;

    // accept stage
    logic              last_in_line;
    logic              last_in_rows;
    logic              col_wrap;
    logic              emit;
    logic [LUMA_W-1:0] luma;
    logic [CHAN_W-1:0] alpha_eff;
    logic [TW:0]       cols_in;
    logic [TW:0]       rows_in;
    logic [CNT_W-1:0]  count;

    // update stage
    logic              b_valid_reg;
    logic [LUMA_W-1:0] b_luma_reg;
    logic [CHAN_W-1:0] b_alpha_reg;
    logic [CW-1:0]     b_slot_reg;
    logic              b_first_reg;
    logic              b_emit_reg;
    logic [CNT_W-1:0]  b_count_reg;
    tile_flags_t       b_flags_reg;

    logic [2*SUM_W-1:0] sum_mem [MAX_WIDTH];
    logic [2*SUM_W-1:0] rd_data_reg;
    logic               fwd_valid_reg;
    logic [CW-1:0]      fwd_slot_reg;
    logic [2*SUM_W-1:0] fwd_data_reg;

    logic [PW-1:0]      gray_prod;
    logic [MEAN_W-1:0]  gray;
    logic [2*SUM_W-1:0] old_sums;
    logic [SUM_W-1:0]   new_gray;
    logic [SUM_W-1:0]   new_alpha;

    always_comb
    begin
        iw_x = XW'(cfg_regs.image_width);
        if (iw_x == '0)
        begin
            w_last = '0;
        end
        else if (iw_x > XW'(MAX_WIDTH))
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(iw_x - XW'(1));
        end

        if (cfg_regs.image_height == '0)
        begin
            h_last = '0;
        end
        else if (cfg_regs.image_height > IMG_H_W'(HEIGHT_LIMIT))
        begin
            h_last = ROW_W'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            h_last = ROW_W'(cfg_regs.image_height - IMG_H_W'(1));
        end

        tw_last = tile_last(cfg_regs.tile_width);
        th_last = tile_last(cfg_regs.tile_height);
    end

    always_comb
    begin
        last_in_line = (col_reg == w_last);
        last_in_rows = (row_reg == h_last);
        col_wrap     = (cit_reg == tw_last);
        emit         = (last_in_line || col_wrap) && (last_in_rows || (rit_reg == th_last));

        luma = LUMA_W'(RED_WEIGHT) * LUMA_W'(pixel.red)
             + LUMA_W'(GREEN_WEIGHT) * LUMA_W'(pixel.green)
             + LUMA_W'(BLUE_WEIGHT) * LUMA_W'(pixel.blue);
        alpha_eff = cfg_regs.use_alpha ? pixel.alpha : {CHAN_W{1'b1}};

        cols_in = (TW + 1)'(cit_reg) + (TW + 1)'(1);
        rows_in = (TW + 1)'(rit_reg) + (TW + 1)'(1);
        count   = CNT_W'(cols_in) * CNT_W'(rows_in);
    end

    // raster advance
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cit_next  = cit_reg;
        rit_next  = rit_reg;
        slot_next = slot_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            cit_next  = '0;
            rit_next  = '0;
            slot_next = '0;
        end
        else if (accept)
        begin
            if (last_in_line)
            begin
                col_next  = '0;
                cit_next  = '0;
                slot_next = '0;
                if (last_in_rows)
                begin
                    row_next = '0;
                    rit_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    rit_next = (rit_reg == th_last) ? '0 : rit_reg + TW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
                if (col_wrap)
                begin
                    cit_next  = '0;
                    slot_next = slot_reg + CW'(1);
                end
                else
                begin
                    cit_next = cit_reg + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cit_reg       <= '0;
            rit_reg       <= '0;
            slot_reg      <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            cit_reg     <= cit_next;
            rit_reg     <= rit_next;
            slot_reg    <= slot_next;
            b_valid_reg <= accept;
            if (b_valid_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_luma_reg               <= luma;
            b_alpha_reg              <= alpha_eff;
            b_slot_reg               <= slot_reg;
            b_first_reg              <= (cit_reg == '0) && (rit_reg == '0);
            b_emit_reg               <= emit;
            b_count_reg              <= count;
            b_flags_reg.end_of_line  <= last_in_line;
            b_flags_reg.end_of_image <= last_in_line && last_in_rows;
        end
        if (b_valid_reg)
        begin
            fwd_slot_reg <= b_slot_reg;
            fwd_data_reg <= {new_gray, new_alpha};
        end
    end

    // sum memory, read at accept, written back in the cycle after
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= sum_mem[slot_reg];
        end
        if (b_valid_reg)
        begin
            sum_mem[b_slot_reg] <= {new_gray, new_alpha};
        end
    end

    always_comb
    begin
        gray_prod = PW'(b_luma_reg) * PW'(GRAY_MULT);
        gray      = MEAN_W'(gray_prod >> GRAY_SHIFT);
        // forward the previous write-back when it hit the same column
        if (fwd_valid_reg && (fwd_slot_reg == b_slot_reg))
        begin
            old_sums = fwd_data_reg;
        end
        else
        begin
            old_sums = rd_data_reg;
        end
        if (b_first_reg)
        begin
            new_gray  = SUM_W'(gray);
            new_alpha = SUM_W'(b_alpha_reg);
        end
        else
        begin
            new_gray  = old_sums[2*SUM_W-1:SUM_W] + SUM_W'(gray);
            new_alpha = old_sums[SUM_W-1:0] + SUM_W'(b_alpha_reg);
        end
    end

    assign tile_valid = b_valid_reg && b_emit_reg;
    assign gray_sum   = new_gray;
    assign alpha_sum  = new_alpha;
    assign tile_count = b_count_reg;
    assign tile_flags = b_flags_reg;

endmodule

@@ sv/baas_div.sv @@
module baas_div import baas_pkg::*; #(
    parameter int MAX_TILE = 16,
    parameter int CNT_W    = $clog2(MAX_TILE * MAX_TILE + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  gray_sum,
    input  logic [SUM_W-1:0]  alpha_sum,
    input  logic [CNT_W-1:0]  tile_count,
    input  tile_flags_t       tile_flags,
    input  logic              res_take,
    output logic              res_valid,
    output logic              busy,
    output logic [MEAN_W-1:0] mean_gray,
    output logic [MEAN_W-1:0] mean_alpha,
    output tile_flags_t       res_flags
);

    localparam int STEP_W = $clog2(MEAN_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MEAN_W - 1);

    localparam logic [1:0] DIV_IDLE = 2'd0;
    localparam logic [1:0] DIV_RUN  = 2'd1;
    localparam logic [1:0] DIV_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg;

    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_g_reg, rem_a_reg;
    logic [MEAN_W-1:0] quo_g_reg, quo_a_reg;
    tile_flags_t       flags_reg;

    logic [CNT_W:0]    trial_g, trial_a;
    logic              fits_g, fits_a;

    // one quotient bit per cycle for both sums; quotient never exceeds 8 bits,
    // so the upper byte of the sum starts as the partial remainder
    always_comb
    begin
        trial_g = {rem_g_reg, quo_g_reg[MEAN_W-1]};
        trial_a = {rem_a_reg, quo_a_reg[MEAN_W-1]};
        fits_g  = (trial_g >= {1'b0, div_reg});
        fits_a  = (trial_a >= {1'b0, div_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (res_take)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DIV_RUN)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == DIV_IDLE) && start)
        begin
            div_reg   <= tile_count;
            rem_g_reg <= CNT_W'(gray_sum >> MEAN_W);
            rem_a_reg <= CNT_W'(alpha_sum >> MEAN_W);
            quo_g_reg <= gray_sum[MEAN_W-1:0];
            quo_a_reg <= alpha_sum[MEAN_W-1:0];
            flags_reg <= tile_flags;
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_g_reg <= fits_g ? CNT_W'(trial_g - {1'b0, div_reg}) : CNT_W'(trial_g);
            rem_a_reg <= fits_a ? CNT_W'(trial_a - {1'b0, div_reg}) : CNT_W'(trial_a);
            quo_g_reg <= {quo_g_reg[MEAN_W-2:0], fits_g};
            quo_a_reg <= {quo_a_reg[MEAN_W-2:0], fits_a};
        end
    end

    assign res_valid  = (state_reg == DIV_DONE);
    assign busy       = (state_reg != DIV_IDLE);
    assign mean_gray  = quo_g_reg;
    assign mean_alpha = quo_a_reg;
    assign res_flags  = flags_reg;

endmodule

@@ sv/block_average_ascii_shader.sv @@
// a tile's character passes the update stage, the divider and the output register
// throughput: one pixel per cycle while no tile closes; a tile-closing pixel holds
//   the pixel channel until the 8-step shared mean divider hands its result on
// reset: position counters, pipeline and output cleared, registers to defaults;
//   the sum memory is not cleared, the first pixel of every tile overwrites its entry
module block_average_ascii_shader import baas_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_TILE  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    baas_stream_if.sink    pixel,
    baas_stream_if.source  glyph,
    baas_stream_if.sink    cfg
);

    localparam int CNT_W = $clog2(MAX_TILE * MAX_TILE + 1);

    // configuration registers, raw as written; clamping happens at use
    cfg_regs_t cfg_regs_reg, cfg_regs_next;
    logic      restart;

    logic      accept;

    // tile handoff from accumulator to divider
    logic              tile_valid;
    logic [SUM_W-1:0]  gray_sum;
    logic [SUM_W-1:0]  alpha_sum;
    logic [CNT_W-1:0]  tile_count;
    tile_flags_t       tile_flags;

    // divider result
    logic              res_valid;
    logic              res_take;
    logic              div_busy;
    logic [MEAN_W-1:0] mean_gray;
    logic [MEAN_W-1:0] mean_alpha;
    tile_flags_t       res_flags;

    // output register
    logic   out_valid_reg, out_valid_next;
    glyph_t glyph_reg;

    // config writes are always taken; any known index restarts the raster
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_regs_next = cfg_regs_reg;
        restart       = 1'b0;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_IMAGE_WIDTH:
                begin
                    cfg_regs_next.image_width = cfg.data.value[IMG_W_W-1:0];
                    restart = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    cfg_regs_next.image_height = cfg.data.value[IMG_H_W-1:0];
                    restart = 1'b1;
                end
                REG_TILE_WIDTH:
                begin
                    cfg_regs_next.tile_width = cfg.data.value[TILE_W-1:0];
                    restart = 1'b1;
                end
                REG_TILE_HEIGHT:
                begin
                    cfg_regs_next.tile_height = cfg.data.value[TILE_W-1:0];
                    restart = 1'b1;
                end
                REG_USE_ALPHA:
                begin
                    cfg_regs_next.use_alpha = cfg.data.value[0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // a pixel is taken only when, should it close a tile, the divider is
    // free in the next cycle: the update stage never stalls
    assign pixel.ready = !div_busy && !tile_valid;
    assign accept      = pixel.valid && pixel.ready;

    baas_accum #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TILE  (MAX_TILE),
        .CNT_W     (CNT_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel      (pixel.data),
        .cfg_regs   (cfg_regs_reg),
        .restart    (restart),
        .tile_valid (tile_valid),
        .gray_sum   (gray_sum),
        .alpha_sum  (alpha_sum),
        .tile_count (tile_count),
        .tile_flags (tile_flags)
    );

    baas_div #(
        .MAX_TILE (MAX_TILE),
        .CNT_W    (CNT_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (tile_valid),
        .gray_sum   (gray_sum),
        .alpha_sum  (alpha_sum),
        .tile_count (tile_count),
        .tile_flags (tile_flags),
        .res_take   (res_take),
        .res_valid  (res_valid),
        .busy       (div_busy),
        .mean_gray  (mean_gray),
        .mean_alpha (mean_alpha),
        .res_flags  (res_flags)
    );

    // output register: the divider result moves in when it is empty or draining
    assign res_take = res_valid && (!out_valid_reg || glyph.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (glyph.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg  <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_regs_reg  <= cfg_regs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // space for zero mean alpha, else the ramp entry for mean gray
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            glyph_reg.char_code    <= char_of(mean_gray, mean_alpha == '0);
            glyph_reg.end_of_line  <= res_flags.end_of_line;
            glyph_reg.end_of_image <= res_flags.end_of_image;
        end
    end

    assign glyph.valid = out_valid_reg;
    assign glyph.data  = glyph_reg;

endmodule

@@ dv/block_average_ascii_shader_test.sv @@
module block_average_ascii_shader_test;
    import baas_pkg::*;

    // geometry limits of the block as built
    localparam int unsigned WIDTH_CAP = 1024;
    localparam int unsigned TILE_CAP  = 16;

    // gray weights, per mille
    localparam int unsigned LUMA_R   = 299;
    localparam int unsigned LUMA_G   = 587;
    localparam int unsigned LUMA_B   = 114;
    localparam int unsigned LUMA_DIV = 1000;
    localparam int unsigned OPAQUE   = 255;

    // character ramp, darkest first
    localparam int unsigned SHADE_STEPS = 10;
    localparam byte unsigned SHADES [SHADE_STEPS] = '{
        " ", ".", ":", "-", "=", "+", "*", "M", "%", "@"
    };

    // registers in the map; every index from REG_COUNT up is unmapped
    localparam int REG_COUNT = 5;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

    localparam int unsigned RANDOM_ITEMS = 250;
    localparam int unsigned PHASE_CAP    = 120;   // pixels per random phase at most
    localparam int unsigned SETTLE       = 24;    // covers the input hold of a tile close and the trip to the output
    localparam int unsigned HOLD_OFF     = 300;   // long receiver stall
    localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no beat anywhere

    typedef enum bit {ROW_REG, ROW_PIXEL} row_kind_e;
    typedef enum int {MIX_NOISE, MIX_EXTREME, MIX_FAINT, MIX_DIM} mix_e;

    // one row of the directed table
    typedef struct {
        row_kind_e kind;
        cfg_t      reg_write;
        pixel_t    px;
        bit        typed;    // expectation written into the row
        bit        yields;   // typed row closes a tile
        glyph_t    want;
    } drill_row_t;

    logic clk;
    logic rst_n;

    baas_stream_if #(.payload_t(pixel_t)) pixel_if ();
    baas_stream_if #(.payload_t(glyph_t)) glyph_if ();
    baas_stream_if #(.payload_t(cfg_t))   cfg_if ();

    block_average_ascii_shader dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_if),
        .glyph (glyph_if),
        .cfg   (cfg_if)
    );

    // ------------------------------------------------------------------
    // tile shading predictor: register copy, raster position, sums
    // ------------------------------------------------------------------
    cfg_regs_t   layout = CFG_RESET;
    int unsigned x_pos  = 0;
    int unsigned y_pos  = 0;
    int unsigned tile_x = 0;
    int unsigned tile_y = 0;
    bit [15:0]   gray_acc  [WIDTH_CAP];
    bit [15:0]   alpha_acc [WIDTH_CAP];

    glyph_t      glyphs_due [$];   // characters still owed by the block
    int unsigned mismatches = 0;
    int unsigned quiet      = 0;
    bit          rush       = 1'b0;   // no idling on either side
    bit          choke      = 1'b0;   // receiver takes one long stall

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void restart_raster();
        x_pos  = 0;
        y_pos  = 0;
        tile_x = 0;
        tile_y = 0;
    endfunction

    // register write as the block sees it; unmapped indexes change nothing
    function automatic void apply_reg(input cfg_t c);
        case (c.index)
            REG_IMAGE_WIDTH:  layout.image_width  = c.value[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: layout.image_height = c.value[IMG_H_W-1:0];
            REG_TILE_WIDTH:   layout.tile_width   = c.value[TILE_W-1:0];
            REG_TILE_HEIGHT:  layout.tile_height  = c.value[TILE_W-1:0];
            REG_USE_ALPHA:    layout.use_alpha    = c.value[0];
            default:          return;
        endcase
        restart_raster();
    endfunction

    // accumulate one pixel; returns 1 with the character when it closes a tile
    function automatic bit shade(input pixel_t px, output glyph_t g);
        int unsigned w, h, tw, th, a, gray, slot, cnt, mean_gray, mean_alpha;
        byte unsigned code;
        bit line_end, rows_end, closes;
        w  = clamp_to(layout.image_width, 1, WIDTH_CAP);
        h  = clamp_to(layout.image_height, 1, HEIGHT_LIMIT);
        tw = clamp_to(layout.tile_width, 1, TILE_CAP);
        th = clamp_to(layout.tile_height, 1, TILE_CAP);
        a  = layout.use_alpha ? px.alpha : OPAQUE;
        gray = (LUMA_R * px.red + LUMA_G * px.green + LUMA_B * px.blue) / LUMA_DIV;
        g = '0;

        if (x_pos >= w || y_pos >= h || tile_x >= tw || tile_y >= th)
        begin
            restart_raster();
        end

        // first pixel of a tile overwrites its column slot
        slot = (x_pos / tw) % WIDTH_CAP;
        if (tile_x == 0 && tile_y == 0)
        begin
            gray_acc[slot]  = 16'(gray);
            alpha_acc[slot] = 16'(a);
        end
        else
        begin
            gray_acc[slot]  = 16'(gray_acc[slot] + gray);
            alpha_acc[slot] = 16'(alpha_acc[slot] + a);
        end

        // tiles at the right and bottom edges are clipped
        line_end = (x_pos == w - 1);
        rows_end = (y_pos == h - 1);
        closes   = (line_end || tile_x == tw - 1) && (rows_end || tile_y == th - 1);

        if (closes)
        begin
            cnt        = (tile_x + 1) * (tile_y + 1);
            mean_gray  = gray_acc[slot] / cnt;
            mean_alpha = alpha_acc[slot] / cnt;
            code = (mean_alpha == 0) ? " " : SHADES[mean_gray * (SHADE_STEPS - 1) / 255];
            g.char_code    = 7'(code);
            g.end_of_line  = line_end;
            g.end_of_image = line_end && rows_end;
        end

        // raster advance, wrapping to a new image after the last pixel
        if (line_end)
        begin
            x_pos  = 0;
            tile_x = 0;
            if (rows_end)
            begin
                y_pos  = 0;
                tile_y = 0;
            end
            else
            begin
                y_pos++;
                tile_y = (tile_y + 1 >= th) ? 0 : tile_y + 1;
            end
        end
        else
        begin
            x_pos++;
            tile_x = (tile_x + 1 >= tw) ? 0 : tile_x + 1;
        end
        return closes;
    endfunction

    // ------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------
    function automatic drill_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                           input int unsigned v);
        drill_row_t row;
        row.kind      = ROW_REG;
        row.reg_write = cfg_t'{index: idx, value: CFG_DATA_W'(v)};
        row.px        = '0;
        row.typed     = 1'b0;
        row.yields    = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic drill_row_t pix_row(input int unsigned r, input int unsigned g,
                                           input int unsigned b, input int unsigned a);
        drill_row_t row;
        row.kind      = ROW_PIXEL;
        row.reg_write = '0;
        row.px        = pixel_t'{red: 8'(r), green: 8'(g), blue: 8'(b), alpha: 8'(a)};
        row.typed     = 1'b0;
        row.yields    = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic drill_row_t typed_row(input int unsigned r, input int unsigned g,
                                             input int unsigned b, input int unsigned a,
                                             input bit yields, input byte unsigned code,
                                             input bit eol, input bit eoi);
        drill_row_t row;
        row        = pix_row(r, g, b, a);
        row.typed  = 1'b1;
        row.yields = yields;
        row.want   = glyph_t'{char_code: 7'(code), end_of_line: eol, end_of_image: eoi};
        return row;
    endfunction

    function automatic pixel_t fresh_pixel(input mix_e mix);
        pixel_t px;
        px = pixel_t'($urandom);
        case (mix)
            MIX_EXTREME:
            begin
                // every channel pinned to 0 or 255
                px.red   = {CHAN_W{px.red[0]}};
                px.green = {CHAN_W{px.green[0]}};
                px.blue  = {CHAN_W{px.blue[0]}};
                px.alpha = {CHAN_W{px.alpha[0]}};
            end
            MIX_FAINT:
            begin
                // alpha of 0 or 1, so tile means often round to zero
                px.alpha = CHAN_W'(px.alpha[0]);
            end
            MIX_DIM:
            begin
                px.red   = px.red >> 4;
                px.green = px.green >> 4;
                px.blue  = px.blue >> 4;
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one pixel beat; valid stays up afterwards so beats can run back to back
    task automatic offer_pixel(input pixel_t px);
        int unsigned gap;
        gap = rush ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            pixel_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_if.valid <= 1'b1;
        pixel_if.data  <= px;
        do @(posedge clk); while (!pixel_if.ready);
    endtask

    task automatic feed_pixel(input pixel_t px);
        glyph_t g;
        offer_pixel(px);
        if (shade(px, g))
        begin
            glyphs_due.push_back(g);
        end
    endtask

    // one register beat; the caller lowers valid after the last one
    task automatic write_reg(input cfg_t c);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= c;
        do @(posedge clk); while (!cfg_if.ready);
        apply_reg(c);
    endtask

    // write the chosen registers with junk above each field, plus an optional
    // write to an unmapped index
    task automatic reconfigure(input cfg_regs_t tgt, input bit [REG_COUNT-1:0] which,
                               input bit stray);
        cfg_t c;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (which[i])
            begin
                c.index = CFG_IDX_W'(i);
                c.value = CFG_DATA_W'($urandom);
                case (c.index)
                    REG_IMAGE_WIDTH:  c.value[IMG_W_W-1:0] = tgt.image_width;
                    REG_IMAGE_HEIGHT: c.value[IMG_H_W-1:0] = tgt.image_height;
                    REG_TILE_WIDTH:   c.value[TILE_W-1:0]  = tgt.tile_width;
                    REG_TILE_HEIGHT:  c.value[TILE_W-1:0]  = tgt.tile_height;
                    REG_USE_ALPHA:    c.value[0]           = tgt.use_alpha;
                    default:
                    begin
                    end
                endcase
                write_reg(c);
            end
        end
        if (stray)
        begin
            write_reg(cfg_t'{index: CFG_IDX_W'($urandom_range(REG_COUNT, 2 ** CFG_IDX_W - 1)),
                             value: CFG_DATA_W'($urandom)});
        end
        cfg_if.valid <= 1'b0;
    endtask

    // block is idle once every owed character is back and the pipeline has
    // had time to flush pixels that close no tile
    task automatic drain();
        while (glyphs_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic close_pixels();
        pixel_if.valid <= 1'b0;
        drain();
    endtask

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // receiver: random stall per beat, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pause;
        glyph_if.ready <= 1'b0;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever
        begin
            if (choke)
            begin
                // hold off while the sender keeps offering, so the block backs up
                glyph_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                choke = 1'b0;
            end
            pause = rush ? 0 : $urandom_range(0, 3);
            if (pause != 0)
            begin
                glyph_if.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            glyph_if.ready <= 1'b1;
            do @(posedge clk); while (!(glyph_if.valid && glyph_if.ready));
        end
    end

    // ------------------------------------------------------------------
    // checker: each character beat against the oldest owed one
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        glyph_t due;
        if (glyph_if.valid && glyph_if.ready)
        begin
            if (glyphs_due.size() == 0)
            begin
                note_mismatch("unexpected char_code", 0, glyph_if.data.char_code);
            end
            else
            begin
                due = glyphs_due.pop_front();
                if (glyph_if.data.char_code !== due.char_code)
                begin
                    note_mismatch("char_code", due.char_code, glyph_if.data.char_code);
                end
                if (glyph_if.data.end_of_line !== due.end_of_line)
                begin
                    note_mismatch("end_of_line", due.end_of_line, glyph_if.data.end_of_line);
                end
                if (glyph_if.data.end_of_image !== due.end_of_image)
                begin
                    note_mismatch("end_of_image", due.end_of_image,
                                  glyph_if.data.end_of_image);
                end
            end
        end
    end

    // watchdog: too long without a beat on any channel
    always @(posedge clk)
    begin
        if ((pixel_if.valid && pixel_if.ready) || (glyph_if.valid && glyph_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet == QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        drill_row_t       drill [33];
        cfg_regs_t        tgt;
        bit [REG_COUNT-1:0] which;
        bit               stray;
        bit               pixels_open;
        bit               regs_open;
        mix_e             mix;
        glyph_t           g;
        int unsigned      n, img, sel, phase, random_pixels;

        pixel_if.valid <= 1'b0;
        pixel_if.data  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;

        drill = '{
            // reset geometry: first pixel of a 2x2 tile, nothing out
            typed_row(0, 0, 0, 0, 1'b0, " ", 1'b0, 1'b0),
            // zero sizes clamp to 1, every pixel is a whole 1x1 image
            reg_row(REG_IMAGE_WIDTH, 0),
            reg_row(REG_IMAGE_HEIGHT, 0),
            reg_row(REG_TILE_WIDTH, 0),
            reg_row(REG_TILE_HEIGHT, 0),
            // alpha ignored while unused: white is the densest glyph
            typed_row(255, 255, 255, 0, 1'b1, "@", 1'b1, 1'b1),
            typed_row(0, 0, 0, 255, 1'b1, " ", 1'b1, 1'b1),
            reg_row(REG_USE_ALPHA, 1),
            // transparent tile gives a space whatever its gray
            typed_row(255, 255, 255, 0, 1'b1, " ", 1'b1, 1'b1),
            typed_row(255, 255, 255, 1, 1'b1, "@", 1'b1, 1'b1),
            pix_row(255, 0, 0, 255),
            pix_row(0, 255, 0, 128),
            pix_row(0, 0, 255, 255),
            pix_row(254, 254, 254, 128),
            // 3x2 image, 2x2 tiles: right column clipped
            reg_row(REG_IMAGE_WIDTH, 3),
            reg_row(REG_IMAGE_HEIGHT, 2),
            reg_row(REG_TILE_WIDTH, 2),
            reg_row(REG_TILE_HEIGHT, 2),
            pix_row(10, 20, 30, 40),
            pix_row(200, 100, 50, 255),
            pix_row(0, 0, 0, 0),
            pix_row(90, 180, 45, 3),
            pix_row(255, 255, 255, 255),
            pix_row(128, 64, 32, 0),
            // oversized tiles clamp to 16, one clipped tile covers the image
            reg_row(REG_TILE_WIDTH, 31),
            reg_row(REG_TILE_HEIGHT, 17),
            pix_row(7, 77, 177, 250),
            pix_row(33, 66, 99, 0),
            pix_row(250, 5, 125, 60),
            // unmapped index: raster position must survive it
            reg_row(REG_NONE, 8191),
            pix_row(1, 2, 3, 4),
            pix_row(240, 230, 220, 210),
            pix_row(60, 120, 180, 240)
        };

        wait (rst_n == 1'b1);
        @(posedge clk);

        // directed table
        pixels_open = 1'b0;
        regs_open   = 1'b0;
        foreach (drill[k])
        begin
            if (drill[k].kind == ROW_REG)
            begin
                if (pixels_open)
                begin
                    close_pixels();
                    pixels_open = 1'b0;
                end
                write_reg(drill[k].reg_write);
                regs_open = 1'b1;
            end
            else
            begin
                if (regs_open)
                begin
                    cfg_if.valid <= 1'b0;
                    regs_open = 1'b0;
                end
                if (drill[k].typed)
                begin
                    offer_pixel(drill[k].px);
                    void'(shade(drill[k].px, g));
                    if (drill[k].yields)
                    begin
                        glyphs_due.push_back(drill[k].want);
                    end
                end
                else
                begin
                    feed_pixel(drill[k].px);
                end
                pixels_open = 1'b1;
            end
        end
        close_pixels();

        // back pressure: 1x2 tiles close often, receiver stalls long
        tgt = '{image_width: 11'd5, image_height: 13'd3, tile_width: 5'd1,
                tile_height: 5'd2, use_alpha: 1'b1};
        reconfigure(tgt, '1, 1'b0);
        rush  = 1'b0;
        choke = 1'b1;
        repeat (45) feed_pixel(fresh_pixel(MIX_NOISE));
        close_pixels();

        // random phases: new geometry, then whole images or a partial run
        phase         = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_ITEMS)
        begin
            tgt = layout;
            sel = $urandom_range(0, 9);
            tgt.image_width  = (sel == 0) ? 11'd0 :
                               (sel == 9) ? 11'($urandom_range(17, 40)) :
                                            11'($urandom_range(1, 16));
            sel = $urandom_range(0, 9);
            tgt.image_height = (sel == 0) ? 13'd0 :
                               (sel == 9) ? 13'($urandom_range(9, 12)) :
                                            13'($urandom_range(1, 8));
            sel = $urandom_range(0, 9);
            tgt.tile_width   = (sel == 0) ? 5'd0 :
                               (sel == 1) ? 5'($urandom_range(17, 31)) :
                               (sel < 4)  ? 5'($urandom_range(9, 16)) :
                                            5'($urandom_range(1, 4));
            sel = $urandom_range(0, 9);
            tgt.tile_height  = (sel == 0) ? 5'd0 :
                               (sel == 1) ? 5'($urandom_range(17, 31)) :
                               (sel < 4)  ? 5'($urandom_range(9, 16)) :
                                            5'($urandom_range(1, 4));
            tgt.use_alpha = 1'($urandom_range(0, 1));

            // sometimes no mapped write at all: the image carries on where it was
            which = (phase == 0) ? '1 :
                    ($urandom_range(0, 7) == 0) ? '0 : REG_COUNT'($urandom);
            stray = (which == '0) || ($urandom_range(0, 5) == 0);
            reconfigure(tgt, which, stray);

            rush = ($urandom_range(0, 3) == 0);
            mix  = mix_e'($urandom_range(0, 3));
            img  = clamp_to(layout.image_width, 1, WIDTH_CAP) *
                   clamp_to(layout.image_height, 1, HEIGHT_LIMIT);
            if ($urandom_range(0, 4) < 3)
            begin
                n = img * ((img > 150) ? 1 : $urandom_range(1, 3));
            end
            else
            begin
                n = $urandom_range(1, 2 * img + 3);
            end
            if (n > PHASE_CAP)
            begin
                n = PHASE_CAP;
            end

            repeat (n) feed_pixel(fresh_pixel(mix));
            random_pixels += n;
            phase++;
            close_pixels();
        end
        rush = 1'b0;

        // widest row: width field at its top clamps to 1024 columns
        tgt = '{image_width: 11'h7FF, image_height: 13'd1, tile_width: 5'd16,
                tile_height: 5'd16, use_alpha: 1'b1};
        reconfigure(tgt, '1, 1'b0);
        repeat (WIDTH_CAP + 4) feed_pixel(fresh_pixel(MIX_NOISE));
        close_pixels();

        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ block_average_ascii_shader.f @@
sv/baas_pkg.sv
sv/baas_stream_if.sv
sv/baas_accum.sv
sv/baas_div.sv
sv/block_average_ascii_shader.sv
dv/block_average_ascii_shader_test.sv
